@@ src/tlaik_pkg.sv @@
// Shared types, constants and step functions for the two-link arm solver.
package tlaik_pkg;

    localparam int COORD_WIDTH   = 16;
    localparam int CORDIC_STAGES = 16;
    localparam int LINK_W        = 15;

    localparam int R2_W      = 2 * COORD_WIDTH;
    localparam int REACH_W   = 2 * LINK_W + 2;
    localparam int CMP_W     = ((R2_W > REACH_W) ? R2_W : REACH_W) + 1;
    localparam int SQ_W      = ((CMP_W - 1 + 16 + 1) / 2) * 2;
    localparam int SQRT_STAGES = SQ_W / 2;

    localparam int THETA_SHIFT = 40 - COORD_WIDTH;
    localparam int ALPHA_SHIFT = 8;
    localparam int TH_W  = COORD_WIDTH + THETA_SHIFT + 3;
    localparam int AL_W  = SQRT_STAGES + ALPHA_SHIFT + 4;
    localparam int ANG_W = 27;
    localparam int Q_W   = ANG_W + 1 - 9;

    localparam int SHOULDER_W = 17;
    localparam int ELBOW_W    = 16;
    localparam int M_TDATA_W  = ((SHOULDER_W + ELBOW_W + 7) / 8) * 8;

    localparam logic [LINK_W-1:0] LINK_RESET = LINK_W'(256);

    localparam logic signed [ANG_W-1:0] DEG180_Z = ANG_W'(11796480);
    localparam logic signed [Q_W-1:0]   DEG180_Q = Q_W'(23040);
    localparam logic signed [Q_W-1:0]   DEG360_Q = Q_W'(46080);
    localparam logic signed [Q_W-1:0]   ROUND_Q  = Q_W'(256);

    // pipeline stage positions
    localparam int S_IN   = 0;
    localparam int S_SQ   = 1;
    localparam int S_PRE  = 2;
    localparam int S_ROOT = 3;
    localparam int S_AL   = S_ROOT + SQRT_STAGES;
    localparam int S_SUM  = S_AL + CORDIC_STAGES;
    localparam int S_OUT  = S_SUM + 1;
    localparam int N_ST   = S_OUT + 1;

    localparam logic signed [ANG_W-1:0] ATAN_TAB [0:31] = '{
        ANG_W'(2949120), ANG_W'(1740967), ANG_W'(919879), ANG_W'(466945),
        ANG_W'(234379),  ANG_W'(117304),  ANG_W'(58666),  ANG_W'(29335),
        ANG_W'(14668),   ANG_W'(7334),    ANG_W'(3667),   ANG_W'(1833),
        ANG_W'(917),     ANG_W'(458),     ANG_W'(229),    ANG_W'(115),
        ANG_W'(57),      ANG_W'(29),      ANG_W'(14),     ANG_W'(7),
        ANG_W'(4),       ANG_W'(2),       ANG_W'(1),      ANG_W'(0),
        ANG_W'(0),       ANG_W'(0),       ANG_W'(0),      ANG_W'(0),
        ANG_W'(0),       ANG_W'(0),       ANG_W'(0),      ANG_W'(0)
    };

    typedef struct packed {
        logic signed [TH_W-1:0]  x;
        logic signed [TH_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } th_t;

    typedef struct packed {
        logic signed [AL_W-1:0]  x;
        logic signed [AL_W-1:0]  y;
        logic signed [ANG_W-1:0] z;
    } al_t;

    typedef struct packed {
        logic [SQ_W-1:0] rem;
        logic [SQ_W-1:0] res;
    } sq_t;

    function automatic th_t th_step(input th_t a, input int unsigned i);
        th_t b;
        logic signed [TH_W-1:0] dx;
        logic signed [TH_W-1:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (!a.y[TH_W-1])
        begin
            b.x = a.x + dx;
            b.y = a.y - dy;
            b.z = a.z + ATAN_TAB[i[4:0]];
        end
        else
        begin
            b.x = a.x - dx;
            b.y = a.y + dy;
            b.z = a.z - ATAN_TAB[i[4:0]];
        end
        return b;
    endfunction

    function automatic al_t al_step(input al_t a, input int unsigned i);
        al_t b;
        logic signed [AL_W-1:0] dx;
        logic signed [AL_W-1:0] dy;
        dx = a.y >>> i;
        dy = a.x >>> i;
        if (!a.y[AL_W-1])
        begin
            b.x = a.x + dx;
            b.y = a.y - dy;
            b.z = a.z + ATAN_TAB[i[4:0]];
        end
        else
        begin
            b.x = a.x - dx;
            b.y = a.y + dy;
            b.z = a.z - ATAN_TAB[i[4:0]];
        end
        return b;
    endfunction

    function automatic sq_t sq_step(input sq_t a, input int unsigned k);
        sq_t b;
        logic [SQ_W-1:0] bitv;
        logic [SQ_W:0]   trial;
        bitv  = SQ_W'(1) << (SQ_W - 2 - 2 * k);
        trial = {1'b0, a.res} + {1'b0, bitv};
        if ({1'b0, a.rem} >= trial)
        begin
            b.rem = a.rem - trial[SQ_W-1:0];
            b.res = (a.res >> 1) + bitv;
        end
        else
        begin
            b.rem = a.rem;
            b.res = a.res >> 1;
        end
        return b;
    endfunction

endpackage

@@ src/two_link_arm_inverse_kinematics.sv @@
// Two-link planar arm inverse kinematics, fully pipelined.
//
// Input words on s_t*: target x and y in signed Q8.8. Result words on m_t*:
// shoulder and elbow angle in degrees * 128, and on m_tuser a flag set for
// a target out of reach or at the origin (angles are then zero).
// The link length is written through cfg_we / cfg_data while the block is
// idle; reset sets it to 1.0 (256).
// Stages after the input register, in order: square, reach test, 24
// square-root digit stages (the target angle CORDIC runs in the first 16 of
// them), 16 CORDIC stages for the elbow offset angle, sum and wrap, clamp.
// Throughput: one word per cycle while the receiver does not stall, set by
// one digit or one CORDIC rotation per stage.
// Every stage holds its own valid bit; a stage advances when it is empty or
// the next one advances, so a stalled receiver holds the output register
// while empty slots further up still fill. No word is lost or repeated.
// Reset empties the pipeline; m_tvalid is low until a word reaches the end.
module two_link_arm_inverse_kinematics (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  logic                                 cfg_we,
    input  logic [tlaik_pkg::LINK_W-1:0]         cfg_data,
    input  logic                                 s_tvalid,
    output logic                                 s_tready,
    // target_x [15:0], target_y [31:16]
    input  logic [2*tlaik_pkg::COORD_WIDTH-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  logic                                 m_tready,
    // shoulder_angle [16:0], elbow_angle [32:17], zeros above
    output logic [tlaik_pkg::M_TDATA_W-1:0]      m_tdata,
    // unreachable [0]
    output logic                                 m_tuser
);
    import tlaik_pkg::*;

    logic [N_ST:0]   adv;
    logic [N_ST-1:0] vld_reg;

    logic signed [COORD_WIDTH-1:0] x0_reg, y0_reg, x1_reg, y1_reg;
    logic [R2_W-2:0]     axx1_reg, ayy1_reg;
    logic [2*LINK_W-1:0] ll1_reg;
    logic [LINK_W-1:0]   link_length_reg;

    th_t  th2_reg;
    sq_t  sqr2_reg, sqh2_reg;
    logic unr2_reg;

    th_t  th_reg  [SQRT_STAGES];
    sq_t  sqr_reg [SQRT_STAGES];
    sq_t  sqh_reg [SQRT_STAGES];
    logic unrs_reg [SQRT_STAGES];

    al_t  al_reg  [CORDIC_STAGES];
    logic signed [ANG_W-1:0] tz_reg [CORDIC_STAGES];
    logic unra_reg [CORDIC_STAGES];

    logic signed [Q_W-1:0] q1_reg, q2_reg;
    logic unrq_reg;
    logic signed [SHOULDER_W-1:0] shoulder_reg;
    logic signed [ELBOW_W-1:0]    elbow_reg;
    logic unro_reg;

    assign adv[N_ST] = m_tready;
    genvar g;
    generate
        for (g = 0; g < N_ST; g++)
        begin : g_adv
            assign adv[g] = !vld_reg[g] || adv[g+1];
        end
    endgenerate

    assign s_tready = adv[S_IN];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg         <= '0;
            link_length_reg <= LINK_RESET;
        end
        else
        begin
            if (cfg_we)
            begin
                link_length_reg <= cfg_data;
            end
            if (adv[0])
            begin
                vld_reg[0] <= s_tvalid;
            end
            for (int i = 1; i < N_ST; i++)
            begin
                if (adv[i])
                begin
                    vld_reg[i] <= vld_reg[i-1];
                end
            end
        end
    end

    // input and squares
    logic [COORD_WIDTH-1:0] ax, ay;
    logic [R2_W-1:0]        axx, ayy;
    assign ax  = x0_reg[COORD_WIDTH-1] ? COORD_WIDTH'(-x0_reg) : COORD_WIDTH'(x0_reg);
    assign ay  = y0_reg[COORD_WIDTH-1] ? COORD_WIDTH'(-y0_reg) : COORD_WIDTH'(y0_reg);
    assign axx = ax * ax;
    assign ayy = ay * ay;

    always_ff @(posedge clk)
    begin
        if (adv[S_IN])
        begin
            x0_reg <= s_tdata[COORD_WIDTH-1:0];
            y0_reg <= s_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
        end
        if (adv[S_SQ])
        begin
            x1_reg   <= x0_reg;
            y1_reg   <= y0_reg;
            axx1_reg <= axx[R2_W-2:0];
            ayy1_reg <= ayy[R2_W-2:0];
            ll1_reg  <= link_length_reg * link_length_reg;
        end
    end

    // reach test and set-up of roots and target angle
    logic [CMP_W-1:0] r2, reach2, diff;
    logic             unr2;
    th_t              th_init;
    logic signed [TH_W-1:0] xs, ys;
    assign r2     = CMP_W'(axx1_reg) + CMP_W'(ayy1_reg);
    assign reach2 = CMP_W'({ll1_reg, 2'b00});
    assign diff   = reach2 - r2;
    assign unr2   = (r2 == '0) || (r2 > reach2);
    assign xs     = TH_W'(x1_reg) <<< THETA_SHIFT;
    assign ys     = TH_W'(y1_reg) <<< THETA_SHIFT;

    always_comb
    begin
        if (x1_reg[COORD_WIDTH-1])
        begin
            th_init.x = -xs;
            th_init.y = -ys;
            th_init.z = y1_reg[COORD_WIDTH-1] ? -DEG180_Z : DEG180_Z;
        end
        else
        begin
            th_init.x = xs;
            th_init.y = ys;
            th_init.z = '0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_PRE])
        begin
            th2_reg      <= th_init;
            sqr2_reg.rem <= SQ_W'(r2) << 16;
            sqr2_reg.res <= '0;
            sqh2_reg.rem <= unr2 ? '0 : (SQ_W'(diff) << 16);
            sqh2_reg.res <= '0;
            unr2_reg     <= unr2;
        end
    end

    // root digits, target angle rotations alongside
    generate
        for (g = 0; g < SQRT_STAGES; g++)
        begin : g_root
            th_t  th_in;
            sq_t  sqr_in, sqh_in;
            logic unr_in;
            if (g == 0)
            begin : g_first
                assign th_in  = th2_reg;
                assign sqr_in = sqr2_reg;
                assign sqh_in = sqh2_reg;
                assign unr_in = unr2_reg;
            end
            else
            begin : g_next
                assign th_in  = th_reg[g-1];
                assign sqr_in = sqr_reg[g-1];
                assign sqh_in = sqh_reg[g-1];
                assign unr_in = unrs_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv[S_ROOT+g])
                begin
                    sqr_reg[g]  <= sq_step(sqr_in, g);
                    sqh_reg[g]  <= sq_step(sqh_in, g);
                    unrs_reg[g] <= unr_in;
                    if (g < CORDIC_STAGES)
                    begin
                        th_reg[g] <= th_step(th_in, g);
                    end
                    else
                    begin
                        th_reg[g] <= th_in;
                    end
                end
            end
        end
    endgenerate

    // elbow offset angle rotations
    al_t al_init;
    assign al_init.x = AL_W'({sqr_reg[SQRT_STAGES-1].res[SQRT_STAGES-1:0], ALPHA_SHIFT'(0)});
    assign al_init.y = AL_W'({sqh_reg[SQRT_STAGES-1].res[SQRT_STAGES-1:0], ALPHA_SHIFT'(0)});
    assign al_init.z = '0;

    generate
        for (g = 0; g < CORDIC_STAGES; g++)
        begin : g_alpha
            al_t  al_in;
            logic signed [ANG_W-1:0] tz_in;
            logic unr_in;
            if (g == 0)
            begin : g_first
                assign al_in  = al_init;
                assign tz_in  = th_reg[SQRT_STAGES-1].z;
                assign unr_in = unrs_reg[SQRT_STAGES-1];
            end
            else
            begin : g_next
                assign al_in  = al_reg[g-1];
                assign tz_in  = tz_reg[g-1];
                assign unr_in = unra_reg[g-1];
            end
            always_ff @(posedge clk)
            begin
                if (adv[S_AL+g])
                begin
                    al_reg[g]   <= al_step(al_in, g);
                    tz_reg[g]   <= tz_in;
                    unra_reg[g] <= unr_in;
                end
            end
        end
    endgenerate

    // sum, round and wrap
    logic signed [ANG_W:0]  sum1, sum2;
    logic signed [Q_W-1:0]  q1, q2, q2w;
    assign sum1 = (ANG_W+1)'(tz_reg[CORDIC_STAGES-1]) + (ANG_W+1)'(al_reg[CORDIC_STAGES-1].z)
                  + (ANG_W+1)'(ROUND_Q);
    assign sum2 = (ANG_W+1)'(tz_reg[CORDIC_STAGES-1]) - (ANG_W+1)'(al_reg[CORDIC_STAGES-1].z)
                  + (ANG_W+1)'(ROUND_Q);
    assign q1   = Q_W'(sum1 >>> 9);
    assign q2   = Q_W'(sum2 >>> 9);
    assign q2w  = (q2 < -DEG180_Q) ? q2 + DEG360_Q : q2;

    always_ff @(posedge clk)
    begin
        if (adv[S_SUM])
        begin
            q1_reg   <= q1;
            q2_reg   <= q2w;
            unrq_reg <= unra_reg[CORDIC_STAGES-1];
        end
    end

    // clamp and output register
    logic signed [Q_W-1:0] q1c, q2c;
    always_comb
    begin
        if (q1_reg < -DEG180_Q)
            q1c = -DEG180_Q;
        else if (q1_reg > DEG360_Q)
            q1c = DEG360_Q;
        else
            q1c = q1_reg;
        if (q2_reg < -DEG180_Q)
            q2c = -DEG180_Q;
        else if (q2_reg > DEG180_Q)
            q2c = DEG180_Q;
        else
            q2c = q2_reg;
    end

    always_ff @(posedge clk)
    begin
        if (adv[S_OUT])
        begin
            shoulder_reg <= unrq_reg ? '0 : SHOULDER_W'(q1c);
            elbow_reg    <= unrq_reg ? '0 : ELBOW_W'(q2c);
            unro_reg     <= unrq_reg;
        end
    end

    assign m_tvalid = vld_reg[S_OUT];
    assign m_tuser  = unro_reg;
    assign m_tdata  = M_TDATA_W'({elbow_reg, shoulder_reg});

    a_root_fits: assert property (@(posedge clk) disable iff (!rst_n)
        vld_reg[S_AL-1] |-> sqr_reg[SQRT_STAGES-1].res[SQ_W-1:SQRT_STAGES] == '0)
        else $error("square root exceeds its digit count");

    a_unreach_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tuser) |-> m_tdata == '0)
        else $error("angles not zero for unreachable target");

    a_shoulder_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (shoulder_reg >= -23040 && shoulder_reg <= 46080))
        else $error("shoulder angle out of range");

    a_elbow_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (elbow_reg >= -23040 && elbow_reg <= 23040))
        else $error("elbow angle out of range");

endmodule

@@ dv/tb_top.sv @@
// Testbench for the two-link arm inverse kinematics solver, checked against a predictor.
module tb_top;
    import tlaik_pkg::*;

    typedef struct {
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        logic               known;
        logic signed [16:0] sh;
        logic signed [15:0] el;
        logic               unr;
    } stim_row_t;

    typedef struct {
        logic signed [16:0] sh;
        logic signed [15:0] el;
        logic               unr;
    } joint_t;

    localparam int LATENCY = 45;
    localparam int WATCHDOG = 20000;
    localparam int N_RANDOM = 1600;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [LINK_W-1:0] cfg_data;
    logic s_tvalid;
    logic s_tready;
    logic [31:0] s_tdata;
    logic m_tvalid;
    logic m_tready;
    logic [M_TDATA_W-1:0] m_tdata;
    logic m_tuser;

    logic [LINK_W-1:0] link_len;
    joint_t joints_due[$];
    int errors = 0;
    int idle_cycles = 0;
    int results_seen = 0;
    int unreach_seen = 0;
    int stall_left = 0;
    bit timed_out = 1'b0;
    bit calm;

    two_link_arm_inverse_kinematics u_dut (
        .clk(clk), .rst_n(rst_n), .cfg_we(cfg_we), .cfg_data(cfg_data),
        .s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
        .m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
        .m_tuser(m_tuser)
    );

    initial clk = 1'b0;
    always #10 clk = ~clk;

    function automatic longint shr_floor(longint v, int s);
        return v >>> s;
    endfunction

    function automatic longint isqrt(longint unsigned v);
        longint unsigned res;
        longint unsigned b;
        res = 0;
        b = 64'd1 << 62;
        while (b > v)
            b >>= 2;
        while (b != 0)
        begin
            if (v >= res + b)
            begin
                v -= res + b;
                res = (res >> 1) + b;
            end
            else
                res >>= 1;
            b >>= 2;
        end
        return longint'(res);
    endfunction

    function automatic longint cordic_angle(longint x, longint y);
        longint z;
        longint dx;
        longint dy;
        z = 0;
        if (x < 0)
        begin
            z = (y >= 0) ? 64'sd11796480 : -64'sd11796480;
            x = -x;
            y = -y;
        end
        for (int i = 0; i < CORDIC_STAGES; i++)
        begin
            dx = shr_floor(y, i);
            dy = shr_floor(x, i);
            if (y >= 0)
            begin
                x += dx;
                y -= dy;
                z += longint'(ATAN_TAB[i]);
            end
            else
            begin
                x -= dx;
                y += dy;
                z -= longint'(ATAN_TAB[i]);
            end
        end
        return z;
    endfunction

    function automatic joint_t solve_joints(logic signed [15:0] tx, logic signed [15:0] ty);
        joint_t j;
        longint x;
        longint y;
        longint unsigned r2;
        longint unsigned reach2;
        longint th;
        longint al;
        longint q1;
        longint q2;
        x = tx;
        y = ty;
        r2 = x * x + y * y;
        reach2 = 4 * longint'(link_len) * longint'(link_len);
        j.sh = '0;
        j.el = '0;
        j.unr = 1'b1;
        if (r2 == 0 || r2 > reach2)
            return j;
        th = cordic_angle(x <<< THETA_SHIFT, y <<< THETA_SHIFT);
        al = cordic_angle(isqrt(r2 << 16) <<< ALPHA_SHIFT,
                          isqrt((reach2 - r2) << 16) <<< ALPHA_SHIFT);
        q1 = shr_floor(th + al + 256, 9);
        q2 = shr_floor(th - al + 256, 9);
        if (q2 < -23040) q2 += 46080;
        if (q1 < -23040) q1 = -23040;
        if (q1 > 46080) q1 = 46080;
        if (q2 < -23040) q2 = -23040;
        if (q2 > 23040) q2 = 23040;
        j.sh = q1[16:0];
        j.el = q2[15:0];
        j.unr = 1'b0;
        return j;
    endfunction

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, want %0d", what, got, want);
        errors++;
    endtask

    always @(posedge clk)
    begin
        if (rst_n && m_tvalid && m_tready)
        begin
            if (joints_due.size() == 0)
            begin
                $display("MISMATCH unexpected result word");
                errors++;
            end
            else
            begin
                joint_t w;
                w = joints_due.pop_front();
                if ($signed(m_tdata[16:0]) !== w.sh)
                    report_mismatch("shoulder", $signed(m_tdata[16:0]), w.sh);
                if ($signed(m_tdata[32:17]) !== w.el)
                    report_mismatch("elbow", $signed(m_tdata[32:17]), w.el);
                if (m_tuser !== w.unr)
                    report_mismatch("unreachable", m_tuser, w.unr);
                if (m_tdata[M_TDATA_W-1:33] !== '0)
                    report_mismatch("pad bits", m_tdata[M_TDATA_W-1:33], 0);
                results_seen++;
                if (w.unr)
                    unreach_seen++;
            end
        end
    end

    // hold ready low in random bursts
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            m_tready <= 1'b0;
            stall_left = 0;
        end
        else if (calm)
            m_tready <= 1'b1;
        else if (!m_tready)
        begin
            if (stall_left > 0)
                stall_left--;
            else
                m_tready <= 1'b1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_tready <= 1'b0;
            stall_left = $urandom_range(0, 3);
        end
    end

    always @(posedge clk)
    begin
        if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
            idle_cycles = 0;
        else
            idle_cycles++;
        if (idle_cycles >= WATCHDOG)
        begin
            $display("Watchdog expired after %0d idle cycles", idle_cycles);
            timed_out = 1'b1;
        end
    end

    task automatic send_word(logic signed [15:0] tx, logic signed [15:0] ty, joint_t want);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            s_tvalid <= 1'b0;
            gap = $urandom_range(1, 4);
            repeat (gap) @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata <= {ty, tx};
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        joints_due.push_back(want);
    endtask

    task automatic drain;
        s_tvalid <= 1'b0;
        while (joints_due.size() != 0 && !timed_out)
            @(posedge clk);
        repeat (LATENCY + 5) @(posedge clk);
    endtask

    task automatic write_link(logic [LINK_W-1:0] v);
        cfg_we <= 1'b1;
        cfg_data <= v;
        @(posedge clk);
        cfg_we <= 1'b0;
        link_len = v;
        @(posedge clk);
    endtask

    task automatic random_point(int kind, output logic signed [15:0] tx,
                                output logic signed [15:0] ty);
        int lim;
        lim = 2 * int'(link_len);
        if (lim > 32767) lim = 32767;
        case (kind)
            0:
            begin
                tx = 16'($urandom);
                ty = 16'($urandom);
            end
            1:
            begin
                tx = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                ty = 0;
            end
            default:
            begin
                tx = 16'(int'($urandom_range(0, 2 * lim)) - lim);
                ty = 16'(int'($urandom_range(0, 2 * lim)) - lim);
            end
        endcase
    endtask

    stim_row_t directed[] = '{
        '{16'sd0, 16'sd0, 1'b1, 17'sd0, 16'sd0, 1'b1},
        '{16'sd512, 16'sd0, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{16'sd0, 16'sd512, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{-16'sd512, 16'sd0, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{16'sd0, -16'sd512, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{16'sd513, 16'sd0, 1'b1, 17'sd0, 16'sd0, 1'b1},
        '{-16'sd256, 16'sd0, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{-16'sd256, -16'sd1, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{-16'sd300, -16'sd100, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{16'sd1, 16'sd0, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{16'sd100, 16'sd200, 1'b0, 17'sd0, 16'sd0, 1'b0},
        '{16'sh7fff, 16'sh7fff, 1'b1, 17'sd0, 16'sd0, 1'b1},
        '{-16'sd32768, -16'sd32768, 1'b1, 17'sd0, 16'sd0, 1'b1},
        '{-16'sd32768, 16'sd0, 1'b1, 17'sd0, 16'sd0, 1'b1}
    };

    logic [LINK_W-1:0] link_set[] = '{15'd1, 15'd32767, 15'd3, 15'd20000, 15'd700, 15'd256};

    initial
    begin
        logic signed [15:0] tx;
        logic signed [15:0] ty;
        joint_t want;
        int per_set;
        calm = 1'b0;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_data = '0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        link_len = LINK_RESET;
        repeat (9) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed[i])
        begin
            want = solve_joints(directed[i].tx, directed[i].ty);
            if (directed[i].known)
            begin
                want.sh = directed[i].sh;
                want.el = directed[i].el;
                want.unr = directed[i].unr;
            end
            send_word(directed[i].tx, directed[i].ty, want);
        end
        drain();

        per_set = N_RANDOM / link_set.size();
        foreach (link_set[k])
        begin
            write_link(link_set[k]);
            if (k == link_set.size() - 1)
                calm = 1'b1;
            for (int n = 0; n < per_set && !timed_out; n++)
            begin
                random_point($urandom_range(0, 9) == 0 ? 0 :
                             ($urandom_range(0, 9) == 0 ? 1 : 2), tx, ty);
                send_word(tx, ty, solve_joints(tx, ty));
            end
            drain();
        end
        write_link(15'd0);
        send_word(16'sd1, 16'sd0, solve_joints(16'sd1, 16'sd0));
        drain();

        $display("Covered %0d result words, %0d unreachable, over %0d link lengths.",
                 results_seen, unreach_seen, link_set.size() + 1);
        if (!timed_out && errors == 0 && joints_due.size() == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

    initial
    begin
        wait (timed_out);
        $display("Some tests failed");
        $finish;
    end
endmodule
